// ===== design/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg: shared types for the circular deque
// Request and response payloads, operation and status codes, the per-cell
// command word and the carry word that walks toward the front cell.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int WordWidth = 32;

   typedef enum logic [1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_BACK  = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } cdq_kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } cdq_status_type;

   typedef struct packed {
      cdq_kind_type                kind;
      logic signed [WordWidth-1:0] value;
   } cdq_req_type;

   typedef struct packed {
      cdq_status_type              status;
      logic signed [WordWidth-1:0] popped_value;
      logic                        is_empty;
      logic                        is_full;
   } cdq_rsp_type;

   // Command broadcast to every cell of the row
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_SHIFT_RIGHT,
      OP_SHIFT_LEFT,
      OP_APPEND,
      OP_COLLECT,
      OP_DROP
   } cdq_op_type;

   typedef struct packed {
      cdq_op_type                  op;
      logic signed [WordWidth-1:0] word;
   } cdq_ctrl_type;

   // Back word on its way to the front cell
   typedef struct packed {
      logic                        valid;
      logic signed [WordWidth-1:0] data;
   } cdq_carry_type;

   typedef enum logic {
      ST_IDLE,
      ST_COLLECT
   } cdq_state_type;

endpackage

// ===== design/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of the deque row
// Holds one word and its valid bit; shifts with its neighbors, appends at the
// first free position, and forwards the back word toward the front.
// ----------------------------------------------------------------------------
module cdq_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  cdq_pkg::cdq_ctrl_type               ctrl,
   input  logic                                left_valid,
   input  logic signed [cdq_pkg::WordWidth-1:0] left_data,
   input  logic                                right_valid,
   input  logic signed [cdq_pkg::WordWidth-1:0] right_data,
   input  cdq_pkg::cdq_carry_type              right_carry,
   output logic                                valid,
   output logic signed [cdq_pkg::WordWidth-1:0] data,
   output cdq_pkg::cdq_carry_type              carry
);
   import cdq_pkg::*;

   logic                        valid_ff, valid_in;
   logic signed [WordWidth-1:0] data_ff, data_in;
   cdq_carry_type               carry_ff, carry_in;
   logic                        is_last;

   // This cell holds the back word
   assign is_last = valid_ff & ~right_valid;

   // Compute next cell contents from the broadcast command
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      carry_in = '0;
      unique case (ctrl.op)
         OP_HOLD: begin
         end
         OP_SHIFT_RIGHT: begin
            valid_in = left_valid;
            data_in  = left_data;
         end
         OP_SHIFT_LEFT: begin
            valid_in = right_valid;
            data_in  = right_data;
         end
         OP_APPEND: begin
            if (!valid_ff && left_valid) begin
               valid_in = 1'b1;
               data_in  = ctrl.word;
            end
         end
         OP_COLLECT: begin
            if (is_last) begin
               carry_in.valid = 1'b1;
               carry_in.data  = data_ff;
            end else begin
               carry_in = right_carry;
            end
         end
         OP_DROP: begin
            if (is_last) begin
               valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Update valid bits under reset, data words every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         carry_ff.valid <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         carry_ff.valid <= carry_in.valid;
      end
      data_ff       <= data_in;
      carry_ff.data <= carry_in.data;
   end

   assign valid = valid_ff;
   assign data  = data_ff;
   assign carry = carry_ff;

endmodule

// ===== design/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue of signed 32-bit words
// Row of DEPTH cells with the front word always in cell 0.
// ----------------------------------------------------------------------------
// Each request pushes or pops one word at either end and yields one response
// with a status, the popped word (zero unless a pop succeeds) and the empty
// and full flags after the request. Push at either end and pop at the front
// complete directly: the whole row shifts or the first free cell takes the
// word. Pop at the back walks the back word one cell per cycle down the carry
// chain and responds when it reaches cell 0. A new request is taken once the
// previous one is done and its response has left the output register or
// leaves it in the same cycle. Rejected requests change nothing.
module circular_deque #(
   parameter int DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cdq_pkg::cdq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cdq_pkg::cdq_rsp_type rsp_data
);
   import cdq_pkg::*;

   localparam int CountWidth = $clog2(DEPTH + 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(DEPTH);
   localparam logic [CountWidth-1:0] CountOne  = CountWidth'(1);

   cdq_state_type           state_ff, state_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   cdq_rsp_type             rsp_data_ff, rsp_data_in;
   logic                    rsp_load;
   logic                    accept;
   logic                    is_full, is_empty;
   cdq_ctrl_type            ctrl;

   logic                    cell_valid [DEPTH];
   logic signed [WordWidth-1:0] cell_data [DEPTH];
   cdq_carry_type           cell_carry [DEPTH];

   assign is_full   = (count_ff == CountFull);
   assign is_empty  = (count_ff == '0);
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.kind == KIND_POP_BACK && !is_empty) begin
               state_in = ST_COLLECT;
            end
         end
         ST_COLLECT: begin
            if (cell_carry[0].valid) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Cell command, count update and response
   always_comb begin
      ctrl.op      = OP_HOLD;
      ctrl.word    = req_data.value;
      count_in     = count_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_load                 = 1'b1;
               rsp_data_in.status       = STATUS_DONE;
               rsp_data_in.popped_value = '0;
               unique case (req_data.kind)
                  KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_data_in.status = STATUS_FULL;
                     end else begin
                        ctrl.op  = (req_data.kind == KIND_PUSH_FRONT) ?
                                   OP_SHIFT_RIGHT : OP_APPEND;
                        count_in = count_ff + CountOne;
                     end
                  end
                  KIND_POP_FRONT: begin
                     if (is_empty) begin
                        rsp_data_in.status = STATUS_EMPTY;
                     end else begin
                        ctrl.op                  = OP_SHIFT_LEFT;
                        rsp_data_in.popped_value = cell_data[0];
                        count_in                 = count_ff - CountOne;
                     end
                  end
                  KIND_POP_BACK: begin
                     if (is_empty) begin
                        rsp_data_in.status = STATUS_EMPTY;
                     end else begin
                        // Start the walk; respond when it reaches cell 0
                        ctrl.op  = OP_COLLECT;
                        rsp_load = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COLLECT: begin
            if (cell_carry[0].valid) begin
               ctrl.op                  = OP_DROP;
               count_in                 = count_ff - CountOne;
               rsp_load                 = 1'b1;
               rsp_data_in.status       = STATUS_DONE;
               rsp_data_in.popped_value = cell_carry[0].data;
            end else begin
               ctrl.op = OP_COLLECT;
            end
         end
         default: begin
         end
      endcase
      rsp_data_in.is_empty = (count_in == '0);
      rsp_data_in.is_full  = (count_in == CountFull);
   end

   // Hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Row of cells, front at index 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                        left_valid, right_valid;
      logic signed [WordWidth-1:0] left_data, right_data;
      cdq_carry_type               right_carry;

      if (i == 0) begin : g_first
         assign left_valid = 1'b1;
         assign left_data  = req_data.value;
      end else begin : g_inner_left
         assign left_valid = cell_valid[i-1];
         assign left_data  = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_valid = 1'b0;
         assign right_data  = '0;
         assign right_carry = '0;
      end else begin : g_inner_right
         assign right_valid = cell_valid[i+1];
         assign right_data  = cell_data[i+1];
         assign right_carry = cell_carry[i+1];
      end

      cdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_valid  (left_valid),
         .left_data   (left_data),
         .right_valid (right_valid),
         .right_data  (right_data),
         .right_carry (right_carry),
         .valid       (cell_valid[i]),
         .data        (cell_data[i]),
         .carry       (cell_carry[i])
      );
   end

   // Occupancy never exceeds the row
   assert property (@(posedge clock) disable iff (reset) count_ff <= CountFull)
      else $error("occupancy above depth");

   // Front cell is filled exactly when the deque is not empty
   assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] == (count_ff != '0))
      else $error("front cell valid disagrees with occupancy");

   // No request taken while the back word is walking
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COLLECT |-> !req_ready && count_ff != '0)
      else $error("request taken during back pop");

   // Carry reaches cell 0 only during a back pop
   assert property (@(posedge clock) disable iff (reset)
      cell_carry[0].valid |-> state_ff == ST_COLLECT)
      else $error("stray carry at front cell");

   // A finished back pop leaves a response behind
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COLLECT && cell_carry[0].valid |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("back pop finished without response");

endmodule

// ===== bench/tb_circular_deque.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_deque: self-checking bench for the circular deque
// Drives push and pop requests at both ends, keeps its own deque of words
// with wrapping front and back indices, and checks every response field
// against the word, status and flags that this deque predicts.
// ----------------------------------------------------------------------------
module tb_circular_deque;

   import cdq_pkg::*;

   localparam int DEPTH       = 8;
   localparam int IndexWidth  = $clog2(DEPTH);
   localparam int RandomCount = 950;
   localparam int CycleLimit  = 250000;
   localparam int MaxReported = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   cdq_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   cdq_rsp_type rsp_data;

   // Predicted deque contents
   logic signed [WordWidth-1:0] ring_words [DEPTH];
   logic [IndexWidth-1:0]       head_idx = '0;
   logic [IndexWidth-1:0]       tail_idx = '0;
   int                          word_count = 0;

   cdq_rsp_type pending_responses [$];
   int          failure_count = 0;
   int          cycle_count = 0;

   circular_deque #(
      .DEPTH(DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [IndexWidth-1:0] ring_next(input logic [IndexWidth-1:0] i);
      return (i == IndexWidth'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IndexWidth-1:0] ring_prev(input logic [IndexWidth-1:0] i);
      return (i == '0) ? IndexWidth'(DEPTH - 1) : i - 1'b1;
   endfunction

   // Apply one request to the predicted deque and return the response it owes
   function automatic cdq_rsp_type predict_deque_op(input cdq_req_type req);
      cdq_rsp_type rsp;
      rsp = '0;
      rsp.status = STATUS_DONE;
      if (req.kind == KIND_PUSH_FRONT || req.kind == KIND_PUSH_BACK) begin
         if (word_count >= DEPTH) begin
            rsp.status = STATUS_FULL;
         end else begin
            if (word_count == 0) begin
               head_idx = '0;
               tail_idx = '0;
               ring_words[0] = req.value;
            end else if (req.kind == KIND_PUSH_FRONT) begin
               head_idx = ring_prev(head_idx);
               ring_words[head_idx] = req.value;
            end else begin
               tail_idx = ring_next(tail_idx);
               ring_words[tail_idx] = req.value;
            end
            word_count++;
         end
      end else begin
         if (word_count == 0) begin
            rsp.status = STATUS_EMPTY;
         end else begin
            if (req.kind == KIND_POP_FRONT) begin
               rsp.popped_value = ring_words[head_idx];
               head_idx = ring_next(head_idx);
            end else begin
               rsp.popped_value = ring_words[tail_idx];
               tail_idx = ring_prev(tail_idx);
            end
            word_count--;
            // last word gone: both ends return to slot zero
            if (word_count == 0) begin
               head_idx = '0;
               tail_idx = '0;
            end
         end
      end
      rsp.is_empty = (word_count == 0);
      rsp.is_full  = (word_count >= DEPTH);
      return rsp;
   endfunction

   task automatic report_failure(input string what);
      failure_count++;
      if (failure_count <= MaxReported) $display("mismatch @%0t: %s", $realtime, what);
   endtask

   // Check each accepted response against the oldest prediction
   always @(posedge clock) begin : check_responses
      cdq_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            report_failure($sformatf(
               "unexpected response status=%0d popped=%0d empty=%0b full=%0b",
               rsp_data.status, rsp_data.popped_value,
               rsp_data.is_empty, rsp_data.is_full));
         end else begin
            want = pending_responses.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.popped_value !== want.popped_value ||
                rsp_data.is_empty !== want.is_empty || rsp_data.is_full !== want.is_full) begin
               report_failure($sformatf({
                  "expected status=%0d popped=%0d empty=%0b full=%0b, ",
                  "got status=%0d popped=%0d empty=%0b full=%0b"},
                  want.status, want.popped_value, want.is_empty, want.is_full,
                  rsp_data.status, rsp_data.popped_value, rsp_data.is_empty,
                  rsp_data.is_full));
            end
         end
      end
   end

   // Stall the response side in changing modes, including stretches with no stall
   always @(negedge clock) begin : rsp_stall_pattern
      int mode;
      int span;
      if (span == 0) begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 80);
      end
      span = span - 1;
      case (mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ready <= ((cycle_count % 8) < 5);
         end
      endcase
   end

   // Hold one request until accepted, then record its prediction
   task automatic send_request(input cdq_kind_type kind, input logic signed [WordWidth-1:0] value);
      cdq_req_type req;
      req.kind  = kind;
      req.value = value;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= req;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_responses.push_back(predict_deque_op(req));
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic wait_all_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   // Pops on the freshly reset deque are rejected; the value sent with them is ignored
   task automatic test_empty_rejects();
      send_request(KIND_POP_FRONT, 32'sh7FFF_FFFF);
      send_request(KIND_POP_BACK, 32'sh8000_0000);
      wait_all_responses();
   endtask

   // Fill from both ends with extreme words, front index wraps, then overflow
   task automatic test_fill_to_full();
      send_request(KIND_PUSH_FRONT, 32'sh8000_0000);
      send_request(KIND_PUSH_FRONT, 32'sh7FFF_FFFF);
      send_request(KIND_PUSH_BACK, 32'sh0000_0000);
      send_request(KIND_PUSH_BACK, -32'sd1);
      send_request(KIND_PUSH_FRONT, 32'sh5555_5555);
      send_request(KIND_PUSH_BACK, 32'shAAAA_AAAA);
      send_request(KIND_PUSH_FRONT, 32'sh0000_0001);
      send_request(KIND_PUSH_BACK, -32'sd2);
      send_request(KIND_PUSH_FRONT, 32'sh1234_5678);
      send_request(KIND_PUSH_BACK, 32'shFEDC_BA98);
      wait_all_responses();
   endtask

   // Drain from both ends, pop once more on empty, then a push and pop at the back
   task automatic test_drain_both_ends();
      for (int i = 0; i < DEPTH; i++) begin
         send_request((i % 2 == 0) ? KIND_POP_BACK : KIND_POP_FRONT, 32'sh0F0F_0F0F);
      end
      send_request(KIND_POP_BACK, 32'sh0);
      send_request(KIND_PUSH_BACK, 32'sh0BAD_CAFE);
      send_request(KIND_POP_BACK, 32'sh0);
      wait_all_responses();
   endtask

   // Random traffic swinging between full and empty, in bursts with gaps
   task automatic test_random_traffic();
      int                          push_weight;
      int                          burst_left;
      logic signed [WordWidth-1:0] word;
      cdq_kind_type                kind;
      push_weight = 50;
      burst_left  = 0;
      for (int n = 0; n < RandomCount; n++) begin
         // change the fill trend now and then
         if ($urandom_range(0, 23) == 0) begin
            case ($urandom_range(0, 2))
               0: push_weight = 80;
               1: push_weight = 20;
               default: push_weight = 50;
            endcase
         end
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0: word = 32'sh8000_0000;
               1: word = 32'sh7FFF_FFFF;
               2: word = -32'sd1;
               default: word = 32'sh0;
            endcase
         end else begin
            word = $urandom;
         end
         if ($urandom_range(1, 100) <= push_weight) begin
            kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
         end else begin
            kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
         end
         if (burst_left == 0) begin
            idle_sender($urandom_range(0, 6));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
         end
         burst_left--;
         send_request(kind, word);
         if (n % 200 == 199) wait_all_responses();
      end
      wait_all_responses();
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_empty_rejects();
      test_fill_to_full();
      test_drain_both_ends();
      test_random_traffic();
      // let a late pop at the back surface before judging
      repeat (2 * DEPTH + 4) @(posedge clock);
      if (failure_count == 0 && pending_responses.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/cdq_pkg.sv
design/cdq_cell.sv
design/circular_deque.sv
bench/tb_circular_deque.sv
